>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, sampled on aclk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define PIDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// check that a condition never holds outside reset
`define PIDC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

>>> rtl/pidc_pkg.sv
// ---------------------------------------------------------------------------
// PID controller package
// Widths, register indexes and the output saturation function.
// ---------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

    localparam int POS_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 8;
    localparam int TICK_W     = 10;
    localparam int OUT_W      = 32;
    localparam int SUM_W      = 40;
    localparam int ERR_W      = POS_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MUL_A_W    = SUM_W;
    localparam int MUL_B_W    = GAIN_W;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W  = $clog2(MUL_B_W);

    localparam int D_PROD_W   = DIFF_W + GAIN_W;
    localparam int DIV_N_W    = D_PROD_W - 1;
    localparam int DIV_CNT_W  = $clog2(DIV_N_W);

    localparam int TOTAL_W    = MUL_P_W + 2;
    localparam int SAT_IN_W   = TOTAL_W - GAIN_FRAC;

    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(20);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SET_POINT,
        CFG_GAIN_P,
        CFG_GAIN_I,
        CFG_GAIN_D,
        CFG_TICK_MS
    } cfg_index_t;

    function automatic logic [OUT_W-1:0] sat_out(input logic [SAT_IN_W-1:0] v);
        logic [SAT_IN_W-OUT_W:0] upper;
        logic [OUT_W-1:0]        res;
        upper = v[SAT_IN_W-1:OUT_W-1];
        if (upper == '0 || upper == '1) begin
            res = v[OUT_W-1:0];
        end else if (v[SAT_IN_W-1]) begin
            res = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pidc_mul.sv
// ---------------------------------------------------------------------------
// PID serial multiplier
// Signed shift-add multiplier, one multiplier bit per cycle, LSB first.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pidc_mul (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [pidc_pkg::MUL_A_W-1:0]  a,
    input  wire logic [pidc_pkg::MUL_B_W-1:0]  b,
    output logic                               done,
    output logic [pidc_pkg::MUL_P_W-1:0]       product
);
    import pidc_pkg::*;

    logic signed [MUL_A_W+1:0]         hi_reg;
    logic        [MUL_B_W-1:0]         lo_reg;
    logic        [MUL_A_W-1:0]         a_reg;
    logic        [MUL_CNT_W-1:0]       cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;

    logic signed [MUL_A_W+1:0]         a_ext;
    logic signed [MUL_A_W+1:0]         addend;
    logic signed [MUL_A_W+1:0]         acc_sum;
    logic                              last;
    logic        [MUL_P_W-1:0]         full;

    always_comb begin
        a_ext = {{2{a_reg[MUL_A_W-1]}}, a_reg};
        last  = (cnt_reg == MUL_CNT_W'(MUL_B_W - 1));
        if (!lo_reg[0]) begin
            addend = '0;
        end else if (last) begin
            addend = -a_ext;
        end else begin
            addend = a_ext;
        end
        acc_sum = hi_reg + addend;
        full    = {hi_reg[MUL_A_W-1:0], lo_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg   <= '0;
            lo_reg   <= '0;
            a_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                hi_reg   <= '0;
                lo_reg   <= b;
                a_reg    <= a;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                hi_reg  <= acc_sum >>> 1;
                lo_reg  <= {acc_sum[0], lo_reg[MUL_B_W-1:1]};
                cnt_reg <= cnt_reg + MUL_CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = full;

    `PIDC_ASSERT(a_mul_no_restart, start |-> !busy_reg, "multiplier started while busy")
    `PIDC_ASSERT(a_mul_done_after_run, done_reg |-> $past(busy_reg), "done without a run")

endmodule

`default_nettype wire

>>> rtl/pidc_div.sv
// ---------------------------------------------------------------------------
// PID serial divider
// Unsigned restoring divider, one quotient bit per cycle, MSB first.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pidc_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [pidc_pkg::DIV_N_W-1:0]  dividend,
    input  wire logic [pidc_pkg::TICK_W-1:0]   divisor,
    output logic                               done,
    output logic [pidc_pkg::DIV_N_W-1:0]       quotient
);
    import pidc_pkg::*;

    logic [DIV_N_W-1:0]   n_reg;
    logic [TICK_W-1:0]    r_reg;
    logic [TICK_W-1:0]    d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [TICK_W:0]      trial;
    logic [TICK_W:0]      trial_diff;
    logic                 q_bit;
    logic                 last;

    always_comb begin
        trial      = {r_reg, n_reg[DIV_N_W-1]};
        trial_diff = trial - {1'b0, d_reg};
        q_bit      = (trial >= {1'b0, d_reg});
        last       = (cnt_reg == DIV_CNT_W'(DIV_N_W - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                n_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                r_reg   <= q_bit ? trial_diff[TICK_W-1:0] : trial[TICK_W-1:0];
                n_reg   <= {n_reg[DIV_N_W-2:0], q_bit};
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = n_reg;

    `PIDC_ASSERT(a_div_done_after_run, done_reg |-> $past(busy_reg) && !busy_reg, "bad div done")

endmodule

`default_nettype wire

>>> rtl/pid_controller_step.sv
// ---------------------------------------------------------------------------
// Discrete PID controller step
// One position sample in, one saturated control value and its change out.
//
//   channel | ports                                   | direction
//   s_      | s_valid s_ready s_measured_position     | in
//   m_      | m_valid m_ready m_control_value/change  | out
//   cfg_    | cfg_wr_en cfg_addr cfg_wdata            | in, write only
//
// Each result takes four 16-step serial multiplies and a 33-step serial
// divide, then scaling.
// s_ready is high only while idle and out of reset; a new sample is taken
// while the last result still waits on m_ready, which holds until the
// transaction completes.
// Synchronous reset clears the loop state and registers (dt to 1), tick_ms to 20.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pid_controller_step (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [pidc_pkg::POS_W-1:0]       s_measured_position,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [pidc_pkg::OUT_W-1:0]            m_control_value,
    output logic [pidc_pkg::OUT_W-1:0]            m_control_change,
    input  wire logic                             cfg_wr_en,
    input  wire logic [pidc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import pidc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDT_GO,
        S_EDT_WAIT,
        S_P_GO,
        S_P_WAIT,
        S_I_GO,
        S_I_WAIT,
        S_D_GO,
        S_D_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SCALE,
        S_FINISH
    } state_t;

    state_t              state_reg;

    logic [POS_W-1:0]    set_point_reg;
    logic [GAIN_W-1:0]   gain_p_reg;
    logic [GAIN_W-1:0]   gain_i_reg;
    logic [GAIN_W-1:0]   gain_d_reg;
    logic [TICK_W-1:0]   tick_ms_reg;

    logic [ERR_W-1:0]    prev_error_reg;
    logic [SUM_W-1:0]    error_sum_reg;
    logic [OUT_W-1:0]    prev_control_reg;

    logic [ERR_W-1:0]    err_reg;
    logic [DIFF_W-1:0]   diff_reg;
    logic [TICK_W-1:0]   dt_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic                neg_reg;
    logic [DIV_N_W-1:0]  div_n_reg;
    logic [OUT_W-1:0]    ctrl_reg;

    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_control_value_reg;
    logic [OUT_W-1:0]    m_control_change_reg;

    logic [ERR_W-1:0]    err_next;
    logic [DIFF_W-1:0]   diff_next;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_next;
    logic [D_PROD_W-1:0] d_prod;
    logic [D_PROD_W-1:0] d_mag;
    logic [TOTAL_W-1:0]  p_ext;
    logic [TOTAL_W-1:0]  q_ext;
    logic [TOTAL_W-1:0]  q_term;
    logic [TOTAL_W-1:0]  t_adj;
    logic [OUT_W-1:0]    ctrl_next;
    logic [OUT_W:0]      change_wide;
    logic [OUT_W-1:0]    change_next;
    logic                out_free;

    logic                mul_start;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic                mul_done;
    logic [MUL_P_W-1:0]  mul_product;
    logic                div_start;
    logic                div_done;
    logic [DIV_N_W-1:0]  div_quotient;

    pidc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    pidc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n_reg),
        .divisor  (dt_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        err_next  = {set_point_reg[POS_W-1], set_point_reg}
                  - {s_measured_position[POS_W-1], s_measured_position};
        diff_next = {err_next[ERR_W-1], err_next} - {prev_error_reg[ERR_W-1], prev_error_reg};

        sum_wide = {error_sum_reg[SUM_W-1], error_sum_reg} + mul_product[SUM_W:0];
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_next = sum_wide[SUM_W-1:0];
        end

        d_prod = mul_product[D_PROD_W-1:0];
        d_mag  = d_prod[D_PROD_W-1] ? -d_prod : d_prod;
        p_ext  = {{(TOTAL_W-MUL_P_W){mul_product[MUL_P_W-1]}}, mul_product};
        q_ext  = {{(TOTAL_W-DIV_N_W){1'b0}}, div_quotient};
        q_term = neg_reg ? -q_ext : q_ext;

        t_adj     = total_reg + {{(TOTAL_W-GAIN_FRAC){1'b0}},
                                 {GAIN_FRAC{total_reg[TOTAL_W-1]}}};
        ctrl_next = sat_out(t_adj[TOTAL_W-1:GAIN_FRAC]);

        change_wide = {ctrl_reg[OUT_W-1], ctrl_reg}
                    - {prev_control_reg[OUT_W-1], prev_control_reg};
        change_next = sat_out({{(SAT_IN_W-OUT_W-1){change_wide[OUT_W]}}, change_wide});

        out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        mul_start = 1'b0;
        mul_a     = {{(MUL_A_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
        mul_b     = {{(MUL_B_W-TICK_W){1'b0}}, dt_reg};
        case (state_reg)
            S_EDT_GO: begin
                mul_start = 1'b1;
            end
            S_P_GO: begin
                mul_start = 1'b1;
                mul_b     = gain_p_reg;
            end
            S_I_GO: begin
                mul_start = 1'b1;
                mul_a     = error_sum_reg;
                mul_b     = gain_i_reg;
            end
            S_D_GO: begin
                mul_start = 1'b1;
                mul_a     = {{(MUL_A_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
                mul_b     = gain_d_reg;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
        div_start = (state_reg == S_DIV_GO);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_point_reg <= '0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            tick_ms_reg   <= TICK_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_addr))
                CFG_SET_POINT: set_point_reg <= cfg_wdata[POS_W-1:0];
                CFG_GAIN_P:    gain_p_reg    <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_I:    gain_i_reg    <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:    gain_d_reg    <= cfg_wdata[GAIN_W-1:0];
                CFG_TICK_MS:   tick_ms_reg   <= cfg_wdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= S_IDLE;
            prev_error_reg       <= '0;
            error_sum_reg        <= '0;
            prev_control_reg     <= '0;
            err_reg              <= '0;
            diff_reg             <= '0;
            dt_reg               <= TICK_W'(1);
            total_reg            <= '0;
            neg_reg              <= 1'b0;
            div_n_reg            <= '0;
            ctrl_reg             <= '0;
            m_valid_reg          <= 1'b0;
            m_control_value_reg  <= '0;
            m_control_change_reg <= '0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        err_reg        <= err_next;
                        diff_reg       <= diff_next;
                        prev_error_reg <= err_next;
                        dt_reg         <= (tick_ms_reg == '0) ? TICK_W'(1) : tick_ms_reg;
                        state_reg      <= S_EDT_GO;
                    end
                end
                S_EDT_GO: state_reg <= S_EDT_WAIT;
                S_EDT_WAIT: begin
                    if (mul_done) begin
                        error_sum_reg <= sum_next;
                        state_reg     <= S_P_GO;
                    end
                end
                S_P_GO: state_reg <= S_P_WAIT;
                S_P_WAIT: begin
                    if (mul_done) begin
                        total_reg <= p_ext;
                        state_reg <= S_I_GO;
                    end
                end
                S_I_GO: state_reg <= S_I_WAIT;
                S_I_WAIT: begin
                    if (mul_done) begin
                        total_reg <= total_reg + p_ext;
                        state_reg <= S_D_GO;
                    end
                end
                S_D_GO: state_reg <= S_D_WAIT;
                S_D_WAIT: begin
                    if (mul_done) begin
                        neg_reg   <= d_prod[D_PROD_W-1];
                        div_n_reg <= d_mag[DIV_N_W-1:0];
                        state_reg <= S_DIV_GO;
                    end
                end
                S_DIV_GO: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_done) begin
                        total_reg <= total_reg + q_term;
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    ctrl_reg  <= ctrl_next;
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_valid_reg          <= 1'b1;
                        m_control_value_reg  <= ctrl_reg;
                        m_control_change_reg <= change_next;
                        prev_control_reg     <= ctrl_reg;
                        state_reg            <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready          = (state_reg == S_IDLE) && aresetn;
    assign m_valid          = m_valid_reg;
    assign m_control_value  = m_control_value_reg;
    assign m_control_change = m_control_change_reg;

    `PIDC_ASSERT(a_accept_starts, s_valid && s_ready |=> state_reg == S_EDT_GO, "no start")
    `PIDC_ASSERT(a_result_from_finish, $rose(m_valid_reg) |-> $past(state_reg == S_FINISH), "stray result")
    `PIDC_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_control_value), "result dropped")

endmodule

`default_nettype wire
